@@ design/tas_pkg.sv @@
// Shared constants and types for the triangle affine solver.
// No dependencies; every other design file but tas_queue refers to this package by scope.
package tas_pkg;

    localparam int CoordBitsDef   = 16;
    localparam int FracBitsDef    = 16;
    localparam int CoefBits       = 52;
    localparam int ShiftBits      = 64;
    localparam int ItemQueueDepth = 4;
    localparam int SideQueueDepth = 32;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_DEGEN  = 1'b1;

    // Which coefficient a quotient in the divider belongs to
    typedef enum logic [1:0] {
        LANE_XX = 2'd0,
        LANE_YX = 2'd1,
        LANE_XY = 2'd2,
        LANE_YY = 2'd3
    } lane_t;

    // Tag traveling with each quotient through the divider
    typedef struct packed {
        logic  valid;
        lane_t lane;
    } div_tag_t;

endpackage

@@ design/tas_queue.sv @@
// Small synchronous FIFO with valid/ready on both sides.
// Depends on nothing; DEPTH must be a power of two.
module tas_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/tas_front.sv @@
// Front end: accepts a triangle pair, forms differences, determinant and
// the four Cramer numerators over three stages. Depends on tas_pkg.
module tas_front #(
    parameter int COORD_BITS = tas_pkg::CoordBitsDef,
    parameter int EW         = 1 + 5 * (2 * (COORD_BITS + 1) + 1) + 4 * COORD_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_src_a_x,
    input  logic signed [COORD_BITS-1:0] s_src_a_y,
    input  logic signed [COORD_BITS-1:0] s_src_b_x,
    input  logic signed [COORD_BITS-1:0] s_src_b_y,
    input  logic signed [COORD_BITS-1:0] s_src_c_x,
    input  logic signed [COORD_BITS-1:0] s_src_c_y,
    input  logic signed [COORD_BITS-1:0] s_dst_a_x,
    input  logic signed [COORD_BITS-1:0] s_dst_a_y,
    input  logic signed [COORD_BITS-1:0] s_dst_b_x,
    input  logic signed [COORD_BITS-1:0] s_dst_b_y,
    input  logic signed [COORD_BITS-1:0] s_dst_c_x,
    input  logic signed [COORD_BITS-1:0] s_dst_c_y,
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic [EW-1:0]                q_data
);
    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int PW = 2 * D;
    localparam int NW = PW + 1;

    logic en;

    // Stage 1: differences
    logic                v1_reg;
    logic signed [D-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic signed [D-1:0] pqx_reg, pqy_reg, prx_reg, pry_reg;
    logic signed [C-1:0] px1_reg, py1_reg, ax1_reg, ay1_reg;

    // Stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] d_a_reg, d_b_reg;
    logic signed [PW-1:0] xx_a_reg, xx_b_reg, yx_a_reg, yx_b_reg;
    logic signed [PW-1:0] xy_a_reg, xy_b_reg, yy_a_reg, yy_b_reg;
    logic signed [C-1:0]  px2_reg, py2_reg, ax2_reg, ay2_reg;

    // Stage 3: determinant and numerators
    logic                 v3_reg;
    logic                 degen_reg;
    logic signed [NW-1:0] det_reg, nxx_reg, nyx_reg, nxy_reg, nyy_reg;
    logic signed [C-1:0]  px3_reg, py3_reg, ax3_reg, ay3_reg;
    logic signed [NW-1:0] det_next;

    assign en      = !v3_reg || q_ready;
    assign s_ready = en;
    assign q_valid = v3_reg;
    assign q_data  = {degen_reg, det_reg, nxx_reg, nyx_reg, nxy_reg, nyy_reg,
                      px3_reg, py3_reg, ax3_reg, ay3_reg};
    assign det_next = NW'(d_a_reg) - NW'(d_b_reg);

    // Valid bits of the three stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Datapath, held while the queue is full
    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg <= D'(s_src_a_x) - D'(s_src_b_x);
            dy1_reg <= D'(s_src_a_y) - D'(s_src_b_y);
            dx2_reg <= D'(s_src_a_x) - D'(s_src_c_x);
            dy2_reg <= D'(s_src_a_y) - D'(s_src_c_y);
            pqx_reg <= D'(s_dst_a_x) - D'(s_dst_b_x);
            pqy_reg <= D'(s_dst_a_y) - D'(s_dst_b_y);
            prx_reg <= D'(s_dst_a_x) - D'(s_dst_c_x);
            pry_reg <= D'(s_dst_a_y) - D'(s_dst_c_y);
            px1_reg <= s_dst_a_x;
            py1_reg <= s_dst_a_y;
            ax1_reg <= s_src_a_x;
            ay1_reg <= s_src_a_y;

            d_a_reg  <= PW'(dx1_reg) * PW'(dy2_reg);
            d_b_reg  <= PW'(dx2_reg) * PW'(dy1_reg);
            xx_a_reg <= PW'(pqx_reg) * PW'(dy2_reg);
            xx_b_reg <= PW'(prx_reg) * PW'(dy1_reg);
            yx_a_reg <= PW'(dx1_reg) * PW'(prx_reg);
            yx_b_reg <= PW'(dx2_reg) * PW'(pqx_reg);
            xy_a_reg <= PW'(pqy_reg) * PW'(dy2_reg);
            xy_b_reg <= PW'(pry_reg) * PW'(dy1_reg);
            yy_a_reg <= PW'(dx1_reg) * PW'(pry_reg);
            yy_b_reg <= PW'(dx2_reg) * PW'(pqy_reg);
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;

            det_reg   <= det_next;
            degen_reg <= (det_next == '0);
            nxx_reg   <= NW'(xx_a_reg) - NW'(xx_b_reg);
            nyx_reg   <= NW'(yx_a_reg) - NW'(yx_b_reg);
            nxy_reg   <= NW'(xy_a_reg) - NW'(xy_b_reg);
            nyy_reg   <= NW'(yy_a_reg) - NW'(yy_b_reg);
            px3_reg   <= px2_reg;
            py3_reg   <= py2_reg;
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
        end
    end

endmodule

@@ design/tas_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, one issue a cycle while en is high.
// Quotient is (num * 2^FRAC_BITS) / den. Depends on tas_pkg.
module tas_divider #(
    parameter int NW        = 35,
    parameter int FRAC_BITS = tas_pkg::FracBitsDef,
    parameter int QW        = NW + FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  tas_pkg::div_tag_t  in_tag,
    input  logic [NW-1:0]      in_num,
    input  logic [NW-1:0]      in_den,
    input  logic               in_neg,
    output tas_pkg::div_tag_t  out_tag,
    output logic [QW-1:0]      out_quot,
    output logic               out_neg
);
    logic [QW-1:0]     work_reg [QW];
    logic [NW-1:0]     rem_reg  [QW];
    logic [NW-1:0]     den_reg  [QW];
    logic              neg_reg  [QW];
    tas_pkg::div_tag_t tag_reg  [QW];

    logic [QW-1:0]     w_in [QW];
    logic [NW-1:0]     r_in [QW];
    logic [NW-1:0]     d_in [QW];
    logic              n_in [QW];
    tas_pkg::div_tag_t t_in [QW];

    assign w_in[0] = {in_num, {FRAC_BITS{1'b0}}};
    assign r_in[0] = '0;
    assign d_in[0] = in_den;
    assign n_in[0] = in_neg;
    assign t_in[0] = in_tag;

    for (genvar i = 1; i < QW; i++) begin : g_link
        assign w_in[i] = work_reg[i-1];
        assign r_in[i] = rem_reg[i-1];
        assign d_in[i] = den_reg[i-1];
        assign n_in[i] = neg_reg[i-1];
        assign t_in[i] = tag_reg[i-1];
    end

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [NW:0] trial;
        logic        ge;

        // Bring down one dividend bit, subtract if it fits
        assign trial = {r_in[i], w_in[i][QW-1]};
        assign ge    = (trial >= {1'b0, d_in[i]});

        always_ff @(posedge aclk) begin
            if (en) begin
                work_reg[i] <= {w_in[i][QW-2:0], ge};
                rem_reg[i]  <= ge ? NW'(trial - {1'b0, d_in[i]}) : trial[NW-1:0];
                den_reg[i]  <= d_in[i];
                neg_reg[i]  <= n_in[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[i] <= '0;
            end else if (en) begin
                tag_reg[i] <= t_in[i];
            end
        end
    end

    assign out_tag  = tag_reg[QW-1];
    assign out_quot = work_reg[QW-1];
    assign out_neg  = neg_reg[QW-1];

endmodule

@@ design/tas_back.sv @@
// Back end: issues four divisions per item, collects the coefficients and
// forms the saturated shifts. Depends on tas_pkg, tas_queue, tas_divider.
module tas_back #(
    parameter int COORD_BITS = tas_pkg::CoordBitsDef,
    parameter int FRAC_BITS  = tas_pkg::FracBitsDef,
    parameter int EW         = 1 + 5 * (2 * (COORD_BITS + 1) + 1) + 4 * COORD_BITS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    q_valid,
    output logic                                    q_ready,
    input  logic [EW-1:0]                           q_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_status,
    output logic signed [tas_pkg::CoefBits-1:0]     m_lin_xx,
    output logic signed [tas_pkg::CoefBits-1:0]     m_lin_xy,
    output logic signed [tas_pkg::CoefBits-1:0]     m_lin_yx,
    output logic signed [tas_pkg::CoefBits-1:0]     m_lin_yy,
    output logic signed [tas_pkg::ShiftBits-1:0]    m_shift_x,
    output logic signed [tas_pkg::ShiftBits-1:0]    m_shift_y
);
    localparam int C   = COORD_BITS;
    localparam int NW  = 2 * (C + 1) + 1;
    localparam int QW  = NW + FRAC_BITS;
    localparam int CB  = tas_pkg::CoefBits;
    localparam int SB  = tas_pkg::ShiftBits;
    localparam int XW  = (QW > CB) ? QW : CB;
    localparam int PRW = CB + C;
    localparam int SW  = PRW + 2;
    localparam int XS  = (SW > SB) ? SW : SB;
    localparam int SDW = 1 + 4 * C;
    localparam int OFS_N = 4 * C;

    // Quotient magnitude to signed coefficient, saturated
    function automatic logic [CB-1:0] to_coef(input logic [QW-1:0] q, input logic neg);
        logic [XW-1:0] qx;
        logic [CB-1:0] qm;
        qx = XW'(q);
        qm = qx[CB-1:0];
        if (qx[XW-1:CB-1] != '0) begin
            return neg ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
        end
        return neg ? CB'(-qm) : qm;
    endfunction

    // Wide sum to 64 bits, saturated
    function automatic logic [SB-1:0] sat_shift(input logic signed [SW-1:0] v);
        logic signed [XS-1:0] vx;
        vx = XS'(v);
        if (vx[XS-1:SB-1] == '0 || vx[XS-1:SB-1] == '1) begin
            return vx[SB-1:0];
        end
        return vx[XS-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    endfunction

    // Unpack the queue head
    logic                 h_degen;
    logic signed [NW-1:0] h_det, h_nxx, h_nyx, h_nxy, h_nyy;
    assign h_degen = q_data[EW-1];
    assign h_det   = q_data[OFS_N + 5*NW - 1 -: NW];
    assign h_nxx   = q_data[OFS_N + 4*NW - 1 -: NW];
    assign h_nyx   = q_data[OFS_N + 3*NW - 1 -: NW];
    assign h_nxy   = q_data[OFS_N + 2*NW - 1 -: NW];
    assign h_nyy   = q_data[OFS_N + NW - 1 -: NW];

    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || m_ready;

    // Issue: one lane per cycle unless stalled; lane XX pushes sideband
    tas_pkg::lane_t    lane_reg;
    logic              issue;
    logic              side_push_ready;
    logic              side_pop_valid;
    logic              side_pop_ready;
    logic [SDW-1:0]    side_pop_data;
    logic signed [NW-1:0] num_sel;
    logic [NW-1:0]     num_mag, den_mag;
    tas_pkg::div_tag_t div_in_tag;
    tas_pkg::div_tag_t div_out_tag;
    logic [QW-1:0]     div_quot;
    logic              div_neg;

    assign issue = en && q_valid &&
                   (lane_reg != tas_pkg::LANE_XX || side_push_ready);
    assign q_ready = issue && (lane_reg == tas_pkg::LANE_YY);

    always_comb begin
        unique case (lane_reg)
            tas_pkg::LANE_XX: num_sel = h_nxx;
            tas_pkg::LANE_YX: num_sel = h_nyx;
            tas_pkg::LANE_XY: num_sel = h_nxy;
            tas_pkg::LANE_YY: num_sel = h_nyy;
            default:          num_sel = h_nxx;
        endcase
    end

    assign num_mag          = num_sel[NW-1] ? NW'(-num_sel) : num_sel;
    assign den_mag          = h_det[NW-1] ? NW'(-h_det) : h_det;
    assign div_in_tag.valid = issue;
    assign div_in_tag.lane  = lane_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg <= tas_pkg::LANE_XX;
        end else if (issue) begin
            lane_reg <= tas_pkg::lane_t'(lane_reg + 2'd1);
        end
    end

    tas_queue #(
        .WIDTH (SDW),
        .DEPTH (tas_pkg::SideQueueDepth)
    ) u_side_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (issue && (lane_reg == tas_pkg::LANE_XX)),
        .push_ready (side_push_ready),
        .push_data  ({h_degen, q_data[4*C-1:0]}),
        .pop_valid  (side_pop_valid),
        .pop_ready  (side_pop_ready),
        .pop_data   (side_pop_data)
    );

    tas_divider #(
        .NW        (NW),
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_tag   (div_in_tag),
        .in_num   (num_mag),
        .in_den   (den_mag),
        .in_neg   (num_sel[NW-1] ^ h_det[NW-1]),
        .out_tag  (div_out_tag),
        .out_quot (div_quot),
        .out_neg  (div_neg)
    );

    // Collect the four coefficients; the last lane closes the item
    logic                 last_lane;
    logic                 col_valid_reg;
    logic signed [CB-1:0] lxx_reg, lyx_reg, lxy_reg, lyy_reg;
    logic                 c_degen_reg;
    logic signed [C-1:0]  c_px_reg, c_py_reg, c_ax_reg, c_ay_reg;
    logic [CB-1:0]        coef_next;

    assign last_lane      = div_out_tag.valid && (div_out_tag.lane == tas_pkg::LANE_YY);
    assign side_pop_ready = en && last_lane && side_pop_valid;
    assign coef_next      = to_coef(div_quot, div_neg);

    always_ff @(posedge aclk) begin
        if (en && div_out_tag.valid) begin
            unique case (div_out_tag.lane)
                tas_pkg::LANE_XX: lxx_reg <= coef_next;
                tas_pkg::LANE_YX: lyx_reg <= coef_next;
                tas_pkg::LANE_XY: lxy_reg <= coef_next;
                tas_pkg::LANE_YY: lyy_reg <= coef_next;
                default:          lxx_reg <= coef_next;
            endcase
        end
        if (en && last_lane) begin
            c_degen_reg <= side_pop_data[SDW-1];
            c_px_reg    <= side_pop_data[4*C-1 -: C];
            c_py_reg    <= side_pop_data[3*C-1 -: C];
            c_ax_reg    <= side_pop_data[2*C-1 -: C];
            c_ay_reg    <= side_pop_data[C-1:0];
        end
    end

    // Products of coefficients with the first source point
    logic                  mv_reg;
    logic signed [PRW-1:0] pxx_reg, pyx_reg, pxy_reg, pyy_reg;
    logic signed [CB-1:0]  mxx_reg, myx_reg, mxy_reg, myy_reg;
    logic                  m_degen_reg;
    logic signed [C-1:0]   m_px_reg, m_py_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pxx_reg     <= PRW'(lxx_reg) * PRW'(c_ax_reg);
            pyx_reg     <= PRW'(lyx_reg) * PRW'(c_ay_reg);
            pxy_reg     <= PRW'(lxy_reg) * PRW'(c_ax_reg);
            pyy_reg     <= PRW'(lyy_reg) * PRW'(c_ay_reg);
            mxx_reg     <= lxx_reg;
            myx_reg     <= lyx_reg;
            mxy_reg     <= lxy_reg;
            myy_reg     <= lyy_reg;
            m_degen_reg <= c_degen_reg;
            m_px_reg    <= c_px_reg;
            m_py_reg    <= c_py_reg;
        end
    end

    // Output register: shifts, saturation, degenerate zeroing
    logic signed [SW-1:0] sum_x, sum_y;
    logic                 o_status_reg;
    logic signed [CB-1:0] o_xx_reg, o_xy_reg, o_yx_reg, o_yy_reg;
    logic signed [SB-1:0] o_sx_reg, o_sy_reg;

    assign sum_x = (SW'(m_px_reg) <<< FRAC_BITS) - SW'(pxx_reg) - SW'(pyx_reg);
    assign sum_y = (SW'(m_py_reg) <<< FRAC_BITS) - SW'(pxy_reg) - SW'(pyy_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            o_status_reg <= m_degen_reg ? tas_pkg::STATUS_DEGEN : tas_pkg::STATUS_OK;
            o_xx_reg     <= m_degen_reg ? '0 : mxx_reg;
            o_xy_reg     <= m_degen_reg ? '0 : mxy_reg;
            o_yx_reg     <= m_degen_reg ? '0 : myx_reg;
            o_yy_reg     <= m_degen_reg ? '0 : myy_reg;
            o_sx_reg     <= m_degen_reg ? '0 : sat_shift(sum_x);
            o_sy_reg     <= m_degen_reg ? '0 : sat_shift(sum_y);
        end
    end

    // Valid bits of collector, product and output stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_valid_reg <= 1'b0;
            mv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            col_valid_reg <= last_lane;
            mv_reg        <= col_valid_reg;
            out_valid_reg <= mv_reg;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_status  = o_status_reg;
    assign m_lin_xx  = o_xx_reg;
    assign m_lin_xy  = o_xy_reg;
    assign m_lin_yx  = o_yx_reg;
    assign m_lin_yy  = o_yy_reg;
    assign m_shift_x = o_sx_reg;
    assign m_shift_y = o_sy_reg;

endmodule

@@ design/triangle_affine_solver.sv @@
// Top level of the triangle affine solver: front end, item queue, back end.
// Depends on tas_pkg, tas_front, tas_queue, tas_back.
//
// Usage: present the three source points and their three images on the s_
// channel; each transfer yields exactly one result on the m_ channel, in
// order. A result carries status (0 map found, 1 degenerate triangle with
// all other fields zero), four Q.FRAC_BITS coefficients truncated toward zero
// and two saturated 64-bit Q.FRAC_BITS shifts.
// Throughput is set by the single divider pipeline, which takes one of the four
// quotients per cycle unless the back end stalls.
// Reset (aresetn low, synchronous) empties every stage and queue.
// When the receiver holds m_ready low the back end freezes in place; the
// four-entry queue then fills from the front end, after which s_ready drops.
module triangle_affine_solver #(
    parameter int COORD_BITS = tas_pkg::CoordBitsDef,
    parameter int FRAC_BITS  = tas_pkg::FracBitsDef
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_BITS-1:0]         s_src_a_x,
    input  logic signed [COORD_BITS-1:0]         s_src_a_y,
    input  logic signed [COORD_BITS-1:0]         s_src_b_x,
    input  logic signed [COORD_BITS-1:0]         s_src_b_y,
    input  logic signed [COORD_BITS-1:0]         s_src_c_x,
    input  logic signed [COORD_BITS-1:0]         s_src_c_y,
    input  logic signed [COORD_BITS-1:0]         s_dst_a_x,
    input  logic signed [COORD_BITS-1:0]         s_dst_a_y,
    input  logic signed [COORD_BITS-1:0]         s_dst_b_x,
    input  logic signed [COORD_BITS-1:0]         s_dst_b_y,
    input  logic signed [COORD_BITS-1:0]         s_dst_c_x,
    input  logic signed [COORD_BITS-1:0]         s_dst_c_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_status,
    output logic signed [tas_pkg::CoefBits-1:0]  m_lin_xx,
    output logic signed [tas_pkg::CoefBits-1:0]  m_lin_xy,
    output logic signed [tas_pkg::CoefBits-1:0]  m_lin_yx,
    output logic signed [tas_pkg::CoefBits-1:0]  m_lin_yy,
    output logic signed [tas_pkg::ShiftBits-1:0] m_shift_x,
    output logic signed [tas_pkg::ShiftBits-1:0] m_shift_y
);
    localparam int EW = 1 + 5 * (2 * (COORD_BITS + 1) + 1) + 4 * COORD_BITS;

    logic          f_valid, f_ready;
    logic [EW-1:0] f_data;
    logic          b_valid, b_ready;
    logic [EW-1:0] b_data;

    tas_front #(
        .COORD_BITS (COORD_BITS),
        .EW         (EW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_src_a_x (s_src_a_x),
        .s_src_a_y (s_src_a_y),
        .s_src_b_x (s_src_b_x),
        .s_src_b_y (s_src_b_y),
        .s_src_c_x (s_src_c_x),
        .s_src_c_y (s_src_c_y),
        .s_dst_a_x (s_dst_a_x),
        .s_dst_a_y (s_dst_a_y),
        .s_dst_b_x (s_dst_b_x),
        .s_dst_b_y (s_dst_b_y),
        .s_dst_c_x (s_dst_c_x),
        .s_dst_c_y (s_dst_c_y),
        .q_valid   (f_valid),
        .q_ready   (f_ready),
        .q_data    (f_data)
    );

    tas_queue #(
        .WIDTH (EW),
        .DEPTH (tas_pkg::ItemQueueDepth)
    ) u_item_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    tas_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .EW         (EW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (b_valid),
        .q_ready   (b_ready),
        .q_data    (b_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_lin_xx  (m_lin_xx),
        .m_lin_xy  (m_lin_xy),
        .m_lin_yx  (m_lin_yx),
        .m_lin_yy  (m_lin_yy),
        .m_shift_x (m_shift_x),
        .m_shift_y (m_shift_y)
    );

endmodule
